// ===== src/tsrs_pkg.sv =====
// ----------------------------------------------------------------------------
// tsrs_pkg
// Shared types and constants of the tracker song row sequencer.
// ----------------------------------------------------------------------------
package tsrs_pkg;

    localparam int ROWS_PER_PATTERN = 64;
    localparam int ROW_W            = $clog2(ROWS_PER_PATTERN);

    localparam logic [8:0] ROW_LAST    = 9'(ROWS_PER_PATTERN - 1);
    localparam logic [7:0] NO_LOOP     = 8'hff;
    localparam logic [7:0] LOOP_MAX    = 8'hff;
    localparam logic [7:0] TEMPO_RESET = 8'd125;
    localparam logic [7:0] SPEED_RESET = 8'd6;
    localparam logic [7:0] SONG_LENGTH_RESET = 8'd1;

    // item modes
    localparam logic [1:0] MODE_BEGIN_ROW = 2'd0;
    localparam logic [1:0] MODE_CHAN_FX   = 2'd1;
    localparam logic [1:0] MODE_END_ROW   = 2'd2;

    // song-level effects
    localparam logic [2:0] FX_NONE  = 3'd0;
    localparam logic [2:0] FX_JUMP  = 3'd1;
    localparam logic [2:0] FX_BREAK = 3'd2;
    localparam logic [2:0] FX_PLOOP = 3'd3;
    localparam logic [2:0] FX_DELAY = 3'd4;
    localparam logic [2:0] FX_TEMPO = 3'd5;
    localparam logic [2:0] FX_SPEED = 3'd6;

    // configuration register indexes
    localparam logic [1:0] REG_SONG_LENGTH = 2'd0;
    localparam logic [1:0] REG_LOOP_START  = 2'd1;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] effect;
        logic [7:0] param;
    } seq_req_t;

    typedef struct packed {
        logic [7:0] cur_position;
        logic [5:0] cur_row;
        logic [8:0] row_ticks;
        logic [7:0] tempo_out;
        logic       loop_marker;
        logic [7:0] loops_done;
    } seq_rsp_t;

    typedef struct packed {
        logic [7:0]       position;
        logic [ROW_W-1:0] row;
        logic [7:0]       pend_position;
        logic [8:0]       pend_row;
        logic [ROW_W-1:0] repeat_row;
        logic [7:0]       repeat_count;
        logic [7:0]       speed;
        logic [8:0]       tick_total;
        logic [7:0]       tempo;
        logic [7:0]       loop_count;
        logic             loop_armed;
    } seq_state_t;

    // sequencer state after reset
    localparam seq_state_t STATE_RESET = '{
        position:      '0,
        row:           '0,
        pend_position: '0,
        pend_row:      '0,
        repeat_row:    '0,
        repeat_count:  '0,
        speed:         SPEED_RESET,
        tick_total:    '0,
        tempo:         TEMPO_RESET,
        loop_count:    '0,
        loop_armed:    1'b1
    };

    // step strobe and request handed from the input stage to the core
    typedef struct packed {
        logic     step;
        seq_req_t req;
    } seq_step_t;

endpackage

// ===== src/tsrs_in_stage.sv =====
// ----------------------------------------------------------------------------
// tsrs_in_stage
// Input request register with valid/ready handshake.
// ----------------------------------------------------------------------------
module tsrs_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tsrs_pkg::seq_req_t s_data,
    input  logic               advance,
    output tsrs_pkg::seq_step_t step_out
);

    logic               valid_reg;
    logic               valid_next;
    tsrs_pkg::seq_req_t req_reg;

    // slot frees when its request moves on this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
    end

    assign step_out.step = valid_reg && advance;
    assign step_out.req  = req_reg;

endmodule

// ===== src/tsrs_core.sv =====
// ----------------------------------------------------------------------------
// tsrs_core
// Song position state, configuration registers and per-request update.
// ----------------------------------------------------------------------------
module tsrs_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_wr_data,
    input  tsrs_pkg::seq_step_t step_in,
    output tsrs_pkg::seq_rsp_t  rsp
);

    tsrs_pkg::seq_state_t st_reg;
    tsrs_pkg::seq_state_t st_next;
    tsrs_pkg::seq_state_t upd;
    logic [7:0]           song_length_reg;
    logic [7:0]           song_length_next;
    logic [7:0]           loop_start_reg;
    logic [7:0]           loop_start_next;
    logic                 marker;
    logic [1:0]           loop_inc;
    logic [8:0]           loop_sum;
    logic [8:0]           rc_inc;
    logic [8:0]           nr;
    logic [7:0]           np;

    always_comb begin
        upd      = st_reg;
        marker   = 1'b0;
        loop_inc = 2'd0;
        rc_inc   = 9'(st_reg.repeat_count) + 9'd1;
        nr       = st_reg.pend_row;
        np       = st_reg.pend_position;

        case (step_in.req.mode)
            tsrs_pkg::MODE_BEGIN_ROW: begin
                upd.tick_total = 9'(st_reg.speed);
                upd.pend_row   = 9'(st_reg.row) + 9'd1;
                if (st_reg.loop_armed && loop_start_reg != tsrs_pkg::NO_LOOP
                        && loop_start_reg == st_reg.position) begin
                    marker         = 1'b1;
                    upd.loop_armed = 1'b0;
                end
            end
            tsrs_pkg::MODE_CHAN_FX: begin
                case (step_in.req.effect)
                    tsrs_pkg::FX_JUMP: begin
                        if (step_in.req.param == st_reg.position) begin
                            loop_inc = 2'd1;
                        end
                        upd.pend_position = step_in.req.param;
                        upd.pend_row      = 9'd0;
                    end
                    tsrs_pkg::FX_BREAK: begin
                        upd.pend_position = st_reg.pend_position + 8'd1;
                        upd.pend_row      = 9'(step_in.req.param);
                    end
                    tsrs_pkg::FX_PLOOP: begin
                        if (step_in.req.param == 8'd0) begin
                            upd.repeat_row = st_reg.row;
                        end else if (rc_inc <= 9'(step_in.req.param)) begin
                            upd.repeat_count  = rc_inc[7:0];
                            upd.pend_row      = 9'(st_reg.repeat_row);
                            upd.pend_position = st_reg.position;
                        end else begin
                            // loop finished
                            upd.repeat_count = 8'd0;
                        end
                    end
                    tsrs_pkg::FX_DELAY: begin
                        upd.tick_total = 9'(st_reg.speed) + 9'(step_in.req.param);
                    end
                    tsrs_pkg::FX_TEMPO: begin
                        upd.tempo = step_in.req.param;
                    end
                    tsrs_pkg::FX_SPEED: begin
                        if (step_in.req.param != 8'd0) begin
                            upd.speed      = step_in.req.param;
                            upd.tick_total = 9'(step_in.req.param);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            tsrs_pkg::MODE_END_ROW: begin
                if (nr > tsrs_pkg::ROW_LAST) begin
                    nr = 9'd0;
                    np = np + 8'd1;
                end
                if (np < st_reg.position) begin
                    loop_inc = loop_inc + 2'd1;
                end
                if (np >= song_length_reg) begin
                    np       = 8'd0;
                    loop_inc = loop_inc + 2'd1;
                end
                upd.position      = np;
                upd.row           = tsrs_pkg::ROW_W'(nr);
                upd.pend_position = np;
                upd.pend_row      = nr;
            end
            default: begin
            end
        endcase

        loop_sum = 9'(st_reg.loop_count) + 9'(loop_inc);
        if (loop_sum > 9'(tsrs_pkg::LOOP_MAX)) begin
            upd.loop_count = tsrs_pkg::LOOP_MAX;
        end else begin
            upd.loop_count = loop_sum[7:0];
        end
    end

    always_comb begin
        st_next          = step_in.step ? upd : st_reg;
        song_length_next = song_length_reg;
        loop_start_next  = loop_start_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tsrs_pkg::REG_SONG_LENGTH: song_length_next = cfg_wr_data;
                tsrs_pkg::REG_LOOP_START: begin
                    loop_start_next    = cfg_wr_data;
                    st_next.loop_armed = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg          <= tsrs_pkg::STATE_RESET;
            song_length_reg <= tsrs_pkg::SONG_LENGTH_RESET;
            loop_start_reg  <= tsrs_pkg::NO_LOOP;
        end else begin
            st_reg          <= st_next;
            song_length_reg <= song_length_next;
            loop_start_reg  <= loop_start_next;
        end
    end

    // response shows the state after the request
    assign rsp.cur_position = upd.position;
    assign rsp.cur_row      = 6'(upd.row);
    assign rsp.row_ticks    = (upd.tick_total == 9'd0) ? 9'd1 : upd.tick_total;
    assign rsp.tempo_out    = upd.tempo;
    assign rsp.loop_marker  = marker;
    assign rsp.loops_done   = upd.loop_count;

endmodule

// ===== src/tracker_song_row_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// tracker_song_row_sequencer_unit
// Song position and row sequencer of a tracker module player.
// ----------------------------------------------------------------------------
// Each request is one event of the player: begin-row, channel effect or
// end-row, and each returns exactly one response with the position, row,
// row tick count, tempo, loop marker and song loop count as they stand after
// that request. Requests enter a one-deep input register; the state update
// from that register and the capture of the response in an output register
// happen in the same cycle, and one request is taken in every cycle while
// the response side keeps up. A stalled response holds the output register
// and so the input register, which then takes a request only while empty.
// Configuration (song length at index 0, loop start at index 1) is written
// by the user through the plain write port only while no request is in
// flight; the block itself does not enforce this. Writing loop start re-arms
// the loop marker. Writes to other indexes are ignored.
// ----------------------------------------------------------------------------
module tracker_song_row_sequencer_unit (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_wr_data,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  tsrs_pkg::seq_req_t s_data,
    // response channel
    output logic               m_valid,
    input  logic               m_ready,
    output tsrs_pkg::seq_rsp_t m_data
);

    logic                advance;
    tsrs_pkg::seq_step_t step;
    tsrs_pkg::seq_rsp_t  rsp;
    logic                m_valid_reg;
    logic                m_valid_next;
    tsrs_pkg::seq_rsp_t  m_data_reg;

    // output register can take a new response when empty or being drained
    assign advance = !m_valid_reg || m_ready;

    tsrs_in_stage u_in_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .advance  (advance),
        .step_out (step)
    );

    // state update happens in the same cycle the response is captured
    tsrs_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .step_in     (step),
        .rsp         (rsp)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = step.step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // response payload, no reset needed
    always_ff @(posedge aclk) begin
        if (step.step) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
